### rtl/reserved_range_table_macros.svh
// assertion macros for the reserved range table
`ifndef RESERVED_RANGE_TABLE_MACROS_SVH
`define RESERVED_RANGE_TABLE_MACROS_SVH

// property checked at every clock edge outside reset
`define RRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a property in the next
`define RRT_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

### rtl/rrt_pkg.sv
// shared types and constants of the reserved range table
`timescale 1ns / 1ps
package rrt_pkg;

  localparam int MAX_ENTRIES_DEF = 32;

  localparam logic [63:0] LIMIT_RESET = 64'h0000_8000_0000_0000;
  localparam logic [63:0] MASK_RESET  = 64'h8000_0000_0000_0002;
  localparam logic [11:0] PAGE_MASK   = 12'hFFF;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ARG    = 3'd1;
  localparam logic [2:0] ST_COUNT_OVF  = 3'd2;
  localparam logic [2:0] ST_RANGE      = 3'd3;
  localparam logic [2:0] ST_FLAGS      = 3'd4;
  localparam logic [2:0] ST_UNRESERVED = 3'd5;
  localparam logic [2:0] ST_OVERLAP    = 3'd6;
  localparam logic [2:0] ST_FULL       = 3'd7;

  localparam logic REQ_RESERVE  = 1'b0;
  localparam logic REQ_VALIDATE = 1'b1;

  localparam logic CFG_LIMIT = 1'b0;
  localparam logic CFG_MASK  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INSERT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic check;
    logic scan_rd;
    logic scan_ev;
    logic shift_init;
    logic shift_rd;
    logic shift_wr;
    logic insert;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic reserve;
    logic go_scan;
    logic scan_more;
    logic hit;
    logic shift_more;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] pages;
    logic [31:0] rtype;
    logic [31:0] rflags;
    logic [63:0] backing;
  } entry_t;

endpackage

### rtl/rrt_ctrl.sv
// controller state machine of the reserved range table
`timescale 1ns / 1ps
module rrt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  rrt_pkg::stat_t stat,
  output rrt_pkg::cmd_t  cmd,
  output logic          in_stall
);
  import rrt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_CHECK;
      S_CHECK:    state_next = stat.go_scan ? S_SCAN_RD : S_DONE;
      S_SCAN_RD: begin
        if (stat.scan_more) state_next = S_SCAN_EV;
        else if (stat.reserve) state_next = S_SHIFT_RD;
        else state_next = S_DONE;
      end
      S_SCAN_EV:  state_next = stat.hit ? S_DONE : S_SCAN_RD;
      S_SHIFT_RD: state_next = stat.shift_more ? S_SHIFT_WR : S_INSERT;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_INSERT:   state_next = S_DONE;
      S_DONE:     if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_CHECK:    cmd.check = 1'b1;
      S_SCAN_RD: begin
        cmd.scan_rd = stat.scan_more;
        cmd.shift_init = !stat.scan_more && stat.reserve;
      end
      S_SCAN_EV:  cmd.scan_ev = 1'b1;
      S_SHIFT_RD: cmd.shift_rd = stat.shift_more;
      S_SHIFT_WR: cmd.shift_wr = 1'b1;
      S_INSERT:   cmd.insert = 1'b1;
      S_DONE:     cmd.finish = stat.out_free;
      default:    cmd = '0;
    endcase
  end

endmodule

### rtl/rrt_dpath.sv
// datapath of the reserved range table: request registers, entry memory, checks
`timescale 1ns / 1ps
`include "reserved_range_table_macros.svh"
module rrt_dpath #(
  parameter int MAX_ENTRIES = rrt_pkg::MAX_ENTRIES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  rrt_pkg::cmd_t  cmd,
  output rrt_pkg::stat_t stat,
  input  logic          cfg_write,
  input  logic          cfg_index,
  input  logic [63:0]   cfg_data,
  input  logic          req_type,
  input  logic [63:0]   virt_address,
  input  logic [63:0]   page_count,
  input  logic [31:0]   region_type,
  input  logic [31:0]   region_flags,
  input  logic [63:0]   backing_address,
  input  logic [63:0]   page_flags,
  input  logic          check_flags,
  input  logic          check_reserved,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          ok,
  output logic [2:0]    status,
  output logic [5:0]    slot_index,
  output logic [5:0]    entries_used
);
  import rrt_pkg::*;

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic [63:0] limit, mask;
  logic        rq_type, chk_f, chk_r;
  logic [63:0] va, pages, backing, pflags, va_end;
  logic [31:0] rtype, rflags;
  logic [2:0]  st;
  logic [CW-1:0] count, idx, ins, slot;
  logic        ins_set;

  entry_t mem [MAX_ENTRIES];
  entry_t rdata;
  logic [IW-1:0] raddr;
  logic [CW-1:0] idx_m1;

  logic [64:0] sum;
  logic        bad_arg, ovf, rng, bad_flags, full;
  logic [63:0] e_end;
  logic        e_wrap, overlap, contain;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_RESET;
      mask  <= MASK_RESET;
    end else if (cfg_write) begin
      if (cfg_index == CFG_LIMIT) limit <= cfg_data;
      else mask <= cfg_data;
    end
  end

  // front checks in priority order
  assign sum       = {1'b0, va} + {1'b0, pages[51:0], 12'h000};
  assign bad_arg   = (pages == 64'd0) || ((va[11:0] & PAGE_MASK) != 12'd0);
  assign ovf       = pages[63:52] != 12'd0;
  assign rng       = ((rq_type == REQ_RESERVE) && (va >= limit)) || sum[64] ||
                     (sum[63:0] > limit);
  assign bad_flags = (rq_type == REQ_VALIDATE) && chk_f && ((pflags & ~mask) != 64'd0);
  assign full      = count >= CW'(MAX_ENTRIES);

  // entry compare against the registered read
  assign e_end   = rdata.base + {rdata.pages[51:0], 12'h000};
  assign e_wrap  = e_end <= rdata.base;
  assign overlap = e_wrap || !((va_end <= rdata.base) || (e_end <= va));
  assign contain = (va >= rdata.base) && (va_end <= e_end);

  assign idx_m1 = idx - CW'(1);
  assign raddr  = cmd.shift_rd ? idx_m1[IW-1:0] : idx[IW-1:0];

  always_comb begin
    stat.reserve    = rq_type == REQ_RESERVE;
    stat.go_scan    = !bad_arg && !ovf && !rng && !bad_flags &&
                      ((rq_type == REQ_RESERVE) ? !full : chk_r);
    stat.scan_more  = idx < count;
    stat.hit        = (rq_type == REQ_RESERVE) ? overlap : contain;
    stat.shift_more = idx > ins;
    stat.out_free   = !out_valid || !out_stall;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.shift_rd) rdata <= mem[raddr];
    if (cmd.shift_wr) mem[idx[IW-1:0]] <= rdata;
    else if (cmd.insert) mem[ins[IW-1:0]] <= '{base: va, pages: pages, rtype: rtype,
                                              rflags: rflags, backing: backing};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rq_type <= req_type;
      va      <= virt_address;
      pages   <= page_count;
      rtype   <= region_type;
      rflags  <= region_flags;
      backing <= backing_address;
      pflags  <= page_flags;
      chk_f   <= check_flags;
      chk_r   <= check_reserved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.insert) count <= count + CW'(1);
      if (cmd.finish) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      va_end  <= sum[63:0];
      idx     <= '0;
      ins     <= count;
      ins_set <= 1'b0;
      slot    <= '0;
      priority if (bad_arg) st <= ST_BAD_ARG;
      else if (ovf) st <= ST_COUNT_OVF;
      else if (rng) st <= ST_RANGE;
      else if (bad_flags) st <= ST_FLAGS;
      else if (rq_type == REQ_RESERVE) st <= full ? ST_FULL : ST_OK;
      else st <= chk_r ? ST_UNRESERVED : ST_OK;
    end
    if (cmd.scan_ev) begin
      idx <= idx + CW'(1);
      if (stat.hit) st <= (rq_type == REQ_RESERVE) ? ST_OVERLAP : ST_OK;
      if ((rq_type == REQ_RESERVE) && !ins_set && (va < rdata.base)) begin
        ins     <= idx;
        ins_set <= 1'b1;
      end
    end
    if (cmd.shift_init) idx <= count;
    if (cmd.shift_wr) idx <= idx_m1;
    if (cmd.insert) slot <= ins;
    if (cmd.finish) begin
      ok           <= st == ST_OK;
      status       <= st;
      slot_index   <= 6'(slot);
      entries_used <= 6'(count);
    end
  end

  `RRT_ASSERT(a_count_bound, count <= CW'(MAX_ENTRIES), "entry count above table size")
  `RRT_ASSERT_NEXT(a_insert_count, cmd.insert, count == $past(count) + CW'(1), "insert lost count")
  `RRT_ASSERT(a_ok_status, !out_valid || (ok == (status == ST_OK)), "ok disagrees with status")

endmodule

### rtl/reserved_range_table.sv
// top level of the reserved range table
// from accept to result beat: front checks decide, or the entries are scanned (read,
// evaluate) to a hit or the end; a reserve with no hit then shifts the entries above
// its slot up (read, write) and inserts; a stalled result beat holds the last state
// throughput: one request at a time, next accept in the cycle after the result registers
// reset: synchronous, empties the table and loads the register defaults
`timescale 1ns / 1ps
module reserved_range_table #(
  parameter int MAX_ENTRIES = rrt_pkg::MAX_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] virt_address,
  input  logic [63:0] page_count,
  input  logic [31:0] region_type,
  input  logic [31:0] region_flags,
  input  logic [63:0] backing_address,
  input  logic [63:0] page_flags,
  input  logic        check_flags,
  input  logic        check_reserved,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        ok,
  output logic [2:0]  status,
  output logic [5:0]  slot_index,
  output logic [5:0]  entries_used
);
  import rrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rrt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rrt_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .req_type        (req_type),
    .virt_address    (virt_address),
    .page_count      (page_count),
    .region_type     (region_type),
    .region_flags    (region_flags),
    .backing_address (backing_address),
    .page_flags      (page_flags),
    .check_flags     (check_flags),
    .check_reserved  (check_reserved),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .ok              (ok),
    .status          (status),
    .slot_index      (slot_index),
    .entries_used    (entries_used)
  );

endmodule

### tb/rrt_checker.sv
// watches the request and result channels of the reserved range table and checks every result
`timescale 1ns / 1ps
module rrt_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [63:0] virt_address,
  input  logic [63:0] page_count,
  input  logic [31:0] region_type,
  input  logic [31:0] region_flags,
  input  logic [63:0] backing_address,
  input  logic [63:0] page_flags,
  input  logic        check_flags,
  input  logic        check_reserved,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        ok,
  input  logic [2:0]  status,
  input  logic [5:0]  slot_index,
  input  logic [5:0]  entries_used,
  output int          errors,
  output int          pending
);
  import rrt_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;

  typedef struct {
    logic       ok;
    logic [2:0] status;
    logic [5:0] slot;
    logic [5:0] used;
  } verdict_t;

  logic [63:0] limit_q, mask_q;
  logic [63:0] tbl_base [DEPTH+1];
  logic [63:0] tbl_pages [DEPTH+1];
  logic [31:0] tbl_type [DEPTH+1];
  logic [31:0] tbl_flags [DEPTH+1];
  logic [63:0] tbl_backing [DEPTH+1];
  int          tbl_used;
  verdict_t    awaited_q[$];

  assign pending = awaited_q.size();

  function automatic logic [63:0] span_end(logic [63:0] b, logic [63:0] p);
    return b + (p << 12);
  endfunction

  function automatic logic collides(logic [63:0] a, logic [63:0] ap,
                                    logic [63:0] b, logic [63:0] bp);
    logic [63:0] ae, be;
    ae = span_end(a, ap);
    be = span_end(b, bp);
    if (ae <= a || be <= b) return 1'b1;
    return !(ae <= b || be <= a);
  endfunction

  // updates the table mirror for a reserve, returns the verdict of one request
  function automatic verdict_t resolve_request();
    verdict_t    v;
    logic [63:0] va, pg, last;
    logic [2:0]  st;
    int          ins;
    logic        hit;
    va = virt_address;
    pg = page_count;
    v.slot = '0;
    last = span_end(va, pg);
    if (pg == 0 || va[11:0] != 12'h0) st = ST_BAD_ARG;
    else if (pg[63:52] != 0) st = ST_COUNT_OVF;
    else if (req_type == REQ_RESERVE) begin
      if (va >= limit_q || last <= va || last > limit_q) st = ST_RANGE;
      else if (tbl_used >= DEPTH) st = ST_FULL;
      else begin
        ins = tbl_used;
        hit = 1'b0;
        for (int i = 0; i < tbl_used; i++) begin
          if (collides(va, pg, tbl_base[i], tbl_pages[i])) hit = 1'b1;
          if (ins == tbl_used && va < tbl_base[i]) ins = i;
        end
        if (hit) st = ST_OVERLAP;
        else begin
          for (int i = tbl_used; i > ins; i--) begin
            tbl_base[i] = tbl_base[i-1];
            tbl_pages[i] = tbl_pages[i-1];
            tbl_type[i] = tbl_type[i-1];
            tbl_flags[i] = tbl_flags[i-1];
            tbl_backing[i] = tbl_backing[i-1];
          end
          tbl_base[ins] = va;
          tbl_pages[ins] = pg;
          tbl_type[ins] = region_type;
          tbl_flags[ins] = region_flags;
          tbl_backing[ins] = backing_address;
          tbl_used++;
          v.slot = ins[5:0];
          st = ST_OK;
        end
      end
    end else begin
      if (last < va || last > limit_q) st = ST_RANGE;
      else if (check_flags && (page_flags & ~mask_q) != 0) st = ST_FLAGS;
      else begin
        hit = 1'b0;
        if (last > va)
          for (int i = 0; i < tbl_used; i++)
            if (va >= tbl_base[i] && last <= span_end(tbl_base[i], tbl_pages[i])) hit = 1'b1;
        st = (check_reserved && !hit) ? ST_UNRESERVED : ST_OK;
      end
    end
    v.ok = (st == ST_OK);
    v.status = st;
    v.used = tbl_used[5:0];
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      limit_q <= LIMIT_RESET;
      mask_q <= MASK_RESET;
      tbl_used = 0;
      for (int i = 0; i <= DEPTH; i++) begin
        tbl_base[i] = '0;
        tbl_pages[i] = '0;
        tbl_type[i] = '0;
        tbl_flags[i] = '0;
        tbl_backing[i] = '0;
      end
      awaited_q.delete();
      errors = 0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_LIMIT) limit_q <= cfg_data;
        else mask_q <= cfg_data;
      end
      if (in_valid && !in_stall) awaited_q.push_back(resolve_request());
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors = errors + 1;
        end else begin
          want = awaited_q.pop_front();
          if (ok !== want.ok) begin
            $error("ok: expected %0d actual %0d", want.ok, ok);
            errors = errors + 1;
          end
          if (status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status);
            errors = errors + 1;
          end
          if (slot_index !== want.slot) begin
            $error("slot_index: expected %0d actual %0d", want.slot, slot_index);
            errors = errors + 1;
          end
          if (entries_used !== want.used) begin
            $error("entries_used: expected %0d actual %0d", want.used, entries_used);
            errors = errors + 1;
          end
        end
      end
    end
  end
endmodule

### tb/tb_reserved_range_table.sv
// stimulus and verdict for the reserved range table
`timescale 1ns / 1ps
module tb_reserved_range_table;
  import rrt_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk, rst;
  logic        cfg_write, cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid, in_stall;
  logic        req_type, check_flags, check_reserved;
  logic [63:0] virt_address, page_count, backing_address, page_flags;
  logic [31:0] region_type, region_flags;
  logic        out_valid, out_stall, ok;
  logic [2:0]  status;
  logic [5:0]  slot_index, entries_used;
  int          errors, pending;
  int          cycles, in_beats;
  int          stall_left;
  logic        calm;
  logic [63:0] cur_limit;

  reserved_range_table dut (.*);
  rrt_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("reserved_range_table test failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (in_valid && !in_stall) in_beats <= in_beats + 1;

  // result side holds off for a random number of cycles after each beat
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n = calm ? 0 : $urandom_range(0, 10);
      stall_left <= n;
      out_stall <= (n != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  task automatic send_request(logic rt, logic [63:0] va, logic [63:0] pg,
                              logic [63:0] pf, logic cf, logic cr);
    int gap;
    int seen;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rt;
    virt_address <= va;
    page_count <= pg;
    region_type <= $urandom;
    region_flags <= $urandom;
    backing_address <= {$urandom, $urandom};
    page_flags <= pf;
    check_flags <= cf;
    check_reserved <= cr;
    seen = in_beats;
    @(posedge clk);
    wait (in_beats != seen);
  endtask

  task automatic write_reg(logic idx, logic [63:0] val);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (150) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_LIMIT) cur_limit = val;
  endtask

  task automatic random_request();
    logic [63:0] va, pg, pf, span;
    int pick;
    pick = $urandom_range(0, 99);
    span = $urandom_range(0, 1) ? 64'd1023 : 64'd65535;
    va = 64'($urandom_range(0, 32'(span))) << 12;
    // keep the ranges close to the limit now and then
    if ($urandom_range(0, 7) == 0 && cur_limit > 64'h10_0000)
      va = (cur_limit - 64'h10_0000) & ~64'hFFF;
    pg = 64'($urandom_range(1, 16));
    pf = $urandom_range(0, 1) ? {$urandom, $urandom} & {$urandom, $urandom} : 64'h2;
    if (pick < 45) send_request(REQ_RESERVE, va, pg, pf, 1'($urandom), 1'($urandom));
    else if (pick < 88) send_request(REQ_VALIDATE, va, pg, pf, 1'($urandom), 1'($urandom));
    else send_request(1'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom), 1'($urandom));
  endtask

  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) calm = ~calm;
      random_request();
    end
  endtask

  initial begin
    rst = 1'b1;
    cycles = 0;
    in_beats = 0;
    calm = 1'b0;
    cur_limit = LIMIT_RESET;
    cfg_write = 1'b0;
    cfg_index = CFG_LIMIT;
    cfg_data = '0;
    in_valid = 1'b0;
    req_type = REQ_RESERVE;
    virt_address = '0;
    page_count = '0;
    region_type = '0;
    region_flags = '0;
    backing_address = '0;
    page_flags = '0;
    check_flags = 1'b0;
    check_reserved = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // argument, overflow, limit, overlap, flags and reservation cases with the reset registers
    send_request(REQ_RESERVE, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, 64'h1234, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'h1000, 64'h0010_0000_0000_0000, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, 64'h1000, '1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, LIMIT_RESET, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, LIMIT_RESET - 64'h1000, 64'h2, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, LIMIT_RESET - 64'h1000, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'h10_000, 64'h4, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'h10_000, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'hE_000, 64'h3, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'h0, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, 64'h11_000, 64'h2, 64'h2, 1'b1, 1'b1);
    send_request(REQ_VALIDATE, 64'h12_000, 64'h4, 64'h2, 1'b1, 1'b1);
    send_request(REQ_VALIDATE, 64'h20_000, 64'h1, 64'h4, 1'b1, 1'b1);
    send_request(REQ_VALIDATE, 64'h20_000, 64'h1, 64'h4, 1'b0, 1'b1);
    send_request(REQ_VALIDATE, LIMIT_RESET - 64'h1000, 64'h2, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, '1, '1, '1, 1'b1, 1'b1);
    random_run(500);

    // no limit: wrapped ends and the top of the space
    write_reg(CFG_LIMIT, '1);
    write_reg(CFG_MASK, '0);
    send_request(REQ_RESERVE, 64'hFFFF_FFFF_FFFF_F000, 64'h2, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, 64'hFFFF_FFFF_FFFF_F000, 64'h2, 64'h0, 1'b0, 1'b0);
    send_request(REQ_RESERVE, 64'hFFFF_FFFF_FFFF_E000, 64'h1, 64'h0, 1'b0, 1'b0);
    send_request(REQ_VALIDATE, 64'hFFFF_FFFF_FFFF_E000, 64'h1, 64'h1, 1'b1, 1'b1);
    send_request(REQ_VALIDATE, 64'hFFFF_FFFF_FFFF_E000, 64'h1, 64'h0, 1'b1, 1'b1);
    random_run(400);

    write_reg(CFG_LIMIT, 64'h0);
    write_reg(CFG_MASK, '1);
    random_run(100);

    write_reg(CFG_LIMIT, 64'h0000_0000_0400_0000);
    write_reg(CFG_MASK, {$urandom, $urandom});
    random_run(500);

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("reserved_range_table test passed");
    else $display("reserved_range_table test failed");
    $finish;
  end
endmodule
